>>> rtl/qmsm_pkg.sv
// Shared types and constants for the quad motor speed mixer.
`default_nettype none

package qmsm_pkg;

  // Field widths
  localparam int CMD_W   = 32;
  localparam int GAIN_W  = 32;
  localparam int SQ_W    = 32;
  localparam int SPEED_W = 16;
  localparam int MOTORS  = 4;
  // Fraction bits of a squared Q8.8 speed
  localparam int SPEED_FRAC2 = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_GAIN   = 2'd2;

  // Gain reset value (1.0 in Q16.16)
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;
  // Saturation limits
  localparam logic [SQ_W-1:0]    SQ_MAX    = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // One command set
  typedef struct packed {
    logic signed [CMD_W-1:0] thrust_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
  } qmsm_in_t;

  // One set of motor speeds
  typedef struct packed {
    logic [SPEED_W-1:0] speed_front;
    logic [SPEED_W-1:0] speed_right;
    logic [SPEED_W-1:0] speed_back;
    logic [SPEED_W-1:0] speed_left;
    logic [MOTORS-1:0]  clamped_mask;
  } qmsm_out_t;

endpackage

`default_nettype wire

>>> rtl/quad_motor_speed_mixer_top.sv
// Quad motor speed mixer: gain products, plus-frame mix, clamp and pipelined square root.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  input    | start, busy, in_data                    | transfer when start && !busy
//  result   | out_valid, out_data                     | one-cycle strobe, no back pressure
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | transfer when valid && ready
//
// One command set enters every cycle while busy is low. The square root takes one result
// bit per stage, ROOT_W stages, and sets the depth; the gain multipliers sit in stage 1.
// A start transfer passes stages 1 to 4, the root stages and the output register.
// Synchronous active-low reset clears the stage valid bits and loads every gain
// with 1.0; busy is high from reset until the first clock edge after reset is
// released. The result side cannot stall, so the pipeline advances every cycle.
`default_nettype none

module quad_motor_speed_mixer_top
  import qmsm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire qmsm_in_t             in_data,
  output      logic                 out_valid,
  output      qmsm_out_t            out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GAIN_W-1:0]    cfg_data
);

  localparam int PROD_W = GAIN_W + CMD_W + 1;
  localparam int SUM_W  = GAIN_W + CMD_W + 2 - FRAC_BITS;
  localparam int LSH    = (FRAC_BITS <= SPEED_FRAC2) ? SPEED_FRAC2 - FRAC_BITS : 0;
  localparam int RSH    = (FRAC_BITS >  SPEED_FRAC2) ? FRAC_BITS - SPEED_FRAC2 : 0;
  localparam int RAD_W  = SQ_W + LSH;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int LAT    = ROOT_W + 5;

  // Gain registers
  logic [GAIN_W-1:0] thrust_gain_r, arm_gain_r, drag_gain_r;
  logic              busy_r;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Register writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_gain_r <= GAIN_RESET;
      arm_gain_r    <= GAIN_RESET;
      drag_gain_r   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRUST_GAIN: thrust_gain_r <= cfg_data;
        REG_ARM_GAIN:    arm_gain_r    <= cfg_data;
        REG_DRAG_GAIN:   drag_gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: exact gain * command products
  logic signed [PROD_W-1:0] p_tt_nxt, p_ap_nxt, p_ar_nxt, p_dy_nxt;
  logic signed [PROD_W-1:0] p_tt_r, p_ap_r, p_ar_r, p_dy_r;
  logic                     s1_valid_r;

  assign p_tt_nxt = $signed({1'b0, thrust_gain_r}) * $signed(in_data.thrust_cmd);
  assign p_ap_nxt = $signed({1'b0, arm_gain_r})    * $signed(in_data.pitch_cmd);
  assign p_ar_nxt = $signed({1'b0, arm_gain_r})    * $signed(in_data.roll_cmd);
  assign p_dy_nxt = $signed({1'b0, drag_gain_r})   * $signed(in_data.yaw_cmd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p_tt_r <= p_tt_nxt;
    p_ap_r <= p_ap_nxt;
    p_ar_r <= p_ar_nxt;
    p_dy_r <= p_dy_nxt;
  end

  // Stage 2: floor shift, offset base and control term per motor
  logic signed [PROD_W-1:0] tt_sh, ap_sh, ar_sh, dy_sh;
  logic signed [SUM_W-1:0]  tt_t, ap_t, ar_t, dy_t, arm_x, drag_x;
  logic signed [SUM_W-1:0]  base_nxt [MOTORS];
  logic signed [SUM_W-1:0]  var_nxt  [MOTORS];
  logic signed [SUM_W-1:0]  base_r   [MOTORS];
  logic signed [SUM_W-1:0]  var_r    [MOTORS];
  logic                     s2_valid_r;

  assign tt_sh  = p_tt_r >>> FRAC_BITS;
  assign ap_sh  = p_ap_r >>> FRAC_BITS;
  assign ar_sh  = p_ar_r >>> FRAC_BITS;
  assign dy_sh  = p_dy_r >>> FRAC_BITS;
  assign tt_t   = tt_sh[SUM_W-1:0];
  assign ap_t   = ap_sh[SUM_W-1:0];
  assign ar_t   = ar_sh[SUM_W-1:0];
  assign dy_t   = dy_sh[SUM_W-1:0];
  assign arm_x  = SUM_W'(arm_gain_r);
  assign drag_x = SUM_W'(drag_gain_r);

  // Plus-frame signs
  assign base_nxt[0] = tt_t + arm_x + drag_x;
  assign var_nxt[0]  = -ar_t - dy_t;
  assign base_nxt[1] = tt_t + arm_x;
  assign var_nxt[1]  = dy_t - ap_t;
  assign base_nxt[2] = tt_t + drag_x;
  assign var_nxt[2]  = ar_t - dy_t;
  assign base_nxt[3] = tt_t;
  assign var_nxt[3]  = ap_t + dy_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    var_r  <= var_nxt;
  end

  // Stage 3: squared speed sum
  logic signed [SUM_W-1:0] sq_r [MOTORS];
  logic                    s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MOTORS; k++) begin
      sq_r[k] <= base_r[k] + var_r[k];
    end
  end

  // Stage 4: clamp to 0..2^32-1 and scale to a Q16 radicand
  logic [SQ_W-1:0]   sq_val   [MOTORS];
  logic [PAD_W-1:0]  rad_nxt  [MOTORS];
  logic [MOTORS-1:0] mask_nxt;

  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      if (sq_r[k][SUM_W-1]) begin
        sq_val[k]   = '0;
        mask_nxt[k] = 1'b1;
      end else if (sq_r[k][SUM_W-2:SQ_W] != '0) begin
        sq_val[k]   = SQ_MAX;
        mask_nxt[k] = 1'b1;
      end else begin
        sq_val[k]   = sq_r[k][SQ_W-1:0];
        mask_nxt[k] = 1'b0;
      end
      rad_nxt[k] = (PAD_W'(sq_val[k]) << LSH) >> RSH;
    end
  end

  // Square root pipeline: one result bit per stage
  logic [PAD_W-1:0]  rad_r  [ROOT_W][MOTORS];
  logic [ROOT_W-1:0] rem_r  [ROOT_W][MOTORS];
  logic [ROOT_W-1:0] root_r [ROOT_W+1][MOTORS];
  logic [MOTORS-1:0] mask_r [ROOT_W+1];
  logic              sv_r   [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    mask_r[0] <= mask_nxt;
    for (int k = 0; k < MOTORS; k++) begin
      rad_r[0][k]  <= rad_nxt[k];
      rem_r[0][k]  <= '0;
      root_r[0][k] <= '0;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    for (genvar k = 0; k < MOTORS; k++) begin : g_lane
      logic [REM_W-1:0] cand, trial;
      logic             take;

      // Bring down two radicand bits, try (root << 2) | 1
      assign cand  = {rem_r[j][k], rad_r[j][k][PAD_W-1 -: 2]};
      assign trial = {root_r[j][k], 2'b01};
      assign take  = (cand >= trial);

      always_ff @(posedge clk) begin
        root_r[j+1][k] <= {root_r[j][k][ROOT_W-2:0], take};
      end

      if (j + 1 < ROOT_W) begin : g_fwd
        logic [REM_W-1:0] diff, nrem;

        assign diff = cand - trial;
        assign nrem = take ? diff : cand;

        always_ff @(posedge clk) begin
          rem_r[j+1][k] <= nrem[ROOT_W-1:0];
          rad_r[j+1][k] <= rad_r[j][k] << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else begin
        sv_r[j+1] <= sv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      mask_r[j+1] <= mask_r[j];
    end
  end

  // Output register with Q8.8 saturation
  logic [SPEED_W-1:0] spd [MOTORS];
  logic               out_valid_r;
  qmsm_out_t          out_data_r;

  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      if (root_r[ROOT_W][k] > ROOT_W'(SPEED_MAX)) begin
        spd[k] = SPEED_MAX;
      end else begin
        spd[k] = root_r[ROOT_W][k][SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.speed_front  <= spd[0];
    out_data_r.speed_right  <= spd[1];
    out_data_r.speed_back   <= spd[2];
    out_data_r.speed_left   <= spd[3];
    out_data_r.clamped_mask <= mask_r[ROOT_W];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every transfer yields a strobe after the fixed pipeline depth
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing after fixed latency");

  // No strobe without a transfer at the matching depth
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without matching transfer");

endmodule

`default_nettype wire
